// File: rtl/core/pbe_pkg.sv
// shared types, codes and microcode table for the planar body euler step
package pbe_pkg;

  localparam int UC_LEN = 13;
  localparam int PC_W = $clog2(UC_LEN);

  // multiplier operand a
  localparam logic [3:0] A_VLONG = 4'd0;
  localparam logic [3:0] A_VLAT = 4'd1;
  localparam logic [3:0] A_YAWRATE = 4'd2;
  localparam logic [3:0] A_FLONG = 4'd3;
  localparam logic [3:0] A_FLAT = 4'd4;
  localparam logic [3:0] A_TORQUE = 4'd5;
  localparam logic [3:0] A_VXDOT = 4'd6;
  localparam logic [3:0] A_VYDOT = 4'd7;
  localparam logic [3:0] A_ALPHA = 4'd8;

  // multiplier operand b
  localparam logic [1:0] B_DT = 2'd0;
  localparam logic [1:0] B_IMASS = 2'd1;
  localparam logic [1:0] B_IINERTIA = 2'd2;
  localparam logic [1:0] B_YAWRATE = 2'd3;

  // write-back destination
  localparam logic [3:0] D_PX = 4'd0;
  localparam logic [3:0] D_PY = 4'd1;
  localparam logic [3:0] D_YAW = 4'd2;
  localparam logic [3:0] D_VLONG = 4'd3;
  localparam logic [3:0] D_VLAT = 4'd4;
  localparam logic [3:0] D_YAWRATE = 4'd5;
  localparam logic [3:0] D_ALONG = 4'd6;
  localparam logic [3:0] D_ALAT = 4'd7;
  localparam logic [3:0] D_VXDOT = 4'd8;
  localparam logic [3:0] D_VYDOT = 4'd9;
  localparam logic [3:0] D_ALPHA = 4'd10;

  // accumulate operand
  localparam logic [1:0] C_ZERO = 2'd0;
  localparam logic [1:0] C_ALONG = 2'd1;
  localparam logic [1:0] C_ALAT = 2'd2;
  localparam logic [1:0] C_DST = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_TIME = 2'd0;
  localparam logic [1:0] CFG_INV_MASS = 2'd1;
  localparam logic [1:0] CFG_INV_INERTIA = 2'd2;

  localparam logic [15:0] STEP_TIME_RST = 16'd655;
  localparam logic [31:0] INV_MASS_RST = 32'd17179869;
  localparam logic [31:0] INV_INERTIA_RST = 32'd42949673;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic       mul_en;
    logic [3:0] a_sel;
    logic [1:0] b_sel;
    logic       wb_en;
    logic [3:0] dst;
    logic [1:0] c_sel;
    logic       sub;
    logic       shift32;
    logic       sat_prod;
    logic       emit;
    logic       last;
  } uword_t;

  typedef struct packed {
    logic   load_in;
    logic   run;
    uword_t uw;
  } pbe_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic uword_t mk(input logic mul_en, input logic [3:0] a_sel,
                                input logic [1:0] b_sel, input logic wb_en,
                                input logic [3:0] dst, input logic [1:0] c_sel,
                                input logic sub, input logic shift32,
                                input logic sat_prod, input logic emit,
                                input logic last);
    uword_t w;
    w.mul_en = mul_en;
    w.a_sel = a_sel;
    w.b_sel = b_sel;
    w.wb_en = wb_en;
    w.dst = dst;
    w.c_sel = c_sel;
    w.sub = sub;
    w.shift32 = shift32;
    w.sat_prod = sat_prod;
    w.emit = emit;
    w.last = last;
    return w;
  endfunction

  // words 0 to 10 multiply, and words 1 to 11 write back the product of the word before
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0: w = mk(1'b1, A_FLONG, B_IMASS, 1'b0, D_PX, C_ZERO,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd1: w = mk(1'b1, A_FLAT, B_IMASS, 1'b1, D_ALONG, C_ZERO,
                   1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      4'd2: w = mk(1'b1, A_VLAT, B_YAWRATE, 1'b1, D_ALAT, C_ZERO,
                   1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      4'd3: w = mk(1'b1, A_VLONG, B_YAWRATE, 1'b1, D_VXDOT, C_ALONG,
                   1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd4: w = mk(1'b1, A_TORQUE, B_IINERTIA, 1'b1, D_VYDOT, C_ALAT,
                   1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      4'd5: w = mk(1'b1, A_VLONG, B_DT, 1'b1, D_ALPHA, C_ZERO,
                   1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      4'd6: w = mk(1'b1, A_VLAT, B_DT, 1'b1, D_PX, C_DST,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd7: w = mk(1'b1, A_YAWRATE, B_DT, 1'b1, D_PY, C_DST,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd8: w = mk(1'b1, A_VXDOT, B_DT, 1'b1, D_YAW, C_DST,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd9: w = mk(1'b1, A_VYDOT, B_DT, 1'b1, D_VLONG, C_DST,
                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd10: w = mk(1'b1, A_ALPHA, B_DT, 1'b1, D_VLAT, C_DST,
                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      4'd11: w = mk(1'b0, A_VLONG, B_DT, 1'b1, D_YAWRATE, C_DST,
                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      default: w = mk(1'b0, A_VLONG, B_DT, 1'b0, D_PX, C_ZERO,
                      1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/planar_body_euler_step.sv
// top level of the planar rigid body euler step
// one microcode word per cycle, unless the emit word stalls on an unclaimed output beat
// a new item is taken only after the last microcode word; eleven products share one 32x33 multiplier
// a finished beat waits in the output register while the next item may be taken
// the last microcode word holds only while an earlier output beat is unclaimed
// reset: body state to zero, step_time 655, inverse_mass 17179869, inverse_inertia 42949673
module planar_body_euler_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] force_long,
  input  logic signed [31:0] force_lat,
  input  logic signed [31:0] yaw_torque,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] vel_long,
  output logic signed [31:0] vel_lat,
  output logic signed [31:0] turn_rate,
  output logic signed [31:0] acc_long,
  output logic signed [31:0] acc_lat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pbe_pkg::*;

  pbe_ctl_t ctl;

  assign cfg_ready = 1'b1;

  pbe_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  pbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .force_long  (force_long),
    .force_lat   (force_lat),
    .yaw_torque  (yaw_torque),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .vel_long    (vel_long),
    .vel_lat     (vel_lat),
    .turn_rate   (turn_rate),
    .acc_long    (acc_long),
    .acc_lat     (acc_lat)
  );

endmodule

// File: rtl/core/pbe_sequencer.sv
// step counter, microcode fetch and handshake control
module pbe_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pbe_pkg::pbe_ctl_t ctl
);
  import pbe_pkg::*;

  logic            busy;
  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            stall;

  assign in_ready = !busy;

  always_comb begin
    uw = ucode(pc);
    // emit waits while the previous beat is still unclaimed
    stall = uw.emit && out_valid && !out_ready;
    ctl.load_in = in_valid && !busy;
    ctl.run = busy && !stall;
    ctl.uw = uw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_in) begin
        busy <= 1'b1;
        pc <= '0;
      end else if (ctl.run) begin
        if (uw.last) begin
          busy <= 1'b0;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
      if (ctl.run && uw.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/pbe_datapath.sv
// state registers, shared multiplier, shift, saturating accumulate and output beat
module pbe_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pbe_pkg::pbe_ctl_t        ctl,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic signed [31:0]       force_long,
  input  logic signed [31:0]       force_lat,
  input  logic signed [31:0]       yaw_torque,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic signed [31:0]       heading,
  output logic signed [31:0]       vel_long,
  output logic signed [31:0]       vel_lat,
  output logic signed [31:0]       turn_rate,
  output logic signed [31:0]       acc_long,
  output logic signed [31:0]       acc_lat
);
  import pbe_pkg::*;

  logic [15:0] step_time;
  logic [31:0] inv_mass;
  logic [31:0] inv_inertia;

  logic signed [31:0] px, py, yaw, vlong, vlat, yawrate, along, alat;
  logic signed [31:0] vx_dot, vy_dot, alpha;
  logic signed [31:0] f_long, f_lat, torque;

  logic signed [31:0] op_a;
  logic signed [32:0] op_b;
  logic signed [64:0] prod;
  logic signed [64:0] shifted;
  logic signed [31:0] shifted_sat;
  logic signed [65:0] term;
  logic signed [31:0] op_c;
  logic signed [31:0] dst_val;
  logic signed [65:0] sum;
  logic signed [31:0] wb_val;

  always_comb begin
    unique case (ctl.uw.a_sel)
      A_VLONG:   op_a = vlong;
      A_VLAT:    op_a = vlat;
      A_YAWRATE: op_a = yawrate;
      A_FLONG:   op_a = f_long;
      A_FLAT:    op_a = f_lat;
      A_TORQUE:  op_a = torque;
      A_VXDOT:   op_a = vx_dot;
      A_VYDOT:   op_a = vy_dot;
      A_ALPHA:   op_a = alpha;
      default:   op_a = '0;
    endcase
    unique case (ctl.uw.b_sel)
      B_DT:       op_b = $signed({17'd0, step_time});
      B_IMASS:    op_b = $signed({1'b0, inv_mass});
      B_IINERTIA: op_b = $signed({1'b0, inv_inertia});
      default:    op_b = {yawrate[31], yawrate};
    endcase
  end

  always_comb begin
    unique case (ctl.uw.dst)
      D_PX:      dst_val = px;
      D_PY:      dst_val = py;
      D_YAW:     dst_val = yaw;
      D_VLONG:   dst_val = vlong;
      D_VLAT:    dst_val = vlat;
      D_YAWRATE: dst_val = yawrate;
      D_ALONG:   dst_val = along;
      D_ALAT:    dst_val = alat;
      D_VXDOT:   dst_val = vx_dot;
      D_VYDOT:   dst_val = vy_dot;
      D_ALPHA:   dst_val = alpha;
      default:   dst_val = '0;
    endcase
    unique case (ctl.uw.c_sel)
      C_ZERO:  op_c = '0;
      C_ALONG: op_c = along;
      C_ALAT:  op_c = alat;
      default: op_c = dst_val;
    endcase
  end

  // floor shift of the registered product, then saturating add or subtract
  always_comb begin
    shifted = ctl.uw.shift32 ? (prod >>> 32) : (prod >>> FRAC_BITS);
    shifted_sat = sat32({shifted[64], shifted});
    term = ctl.uw.sat_prod ? {{34{shifted_sat[31]}}, shifted_sat}
                           : {shifted[64], shifted};
    sum = ctl.uw.sub ? ({{34{op_c[31]}}, op_c} - term)
                     : ({{34{op_c[31]}}, op_c} + term);
    wb_val = sat32(sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.run && ctl.uw.mul_en) begin
      prod <= $signed({{33{op_a[31]}}, op_a}) * $signed({{32{op_b[32]}}, op_b});
    end
    if (ctl.load_in) begin
      f_long <= force_long;
      f_lat <= force_lat;
      torque <= yaw_torque;
    end
    if (ctl.run && ctl.uw.emit) begin
      pos_x <= px;
      pos_y <= py;
      heading <= yaw;
      vel_long <= vlong;
      vel_lat <= vlat;
      turn_rate <= yawrate;
      acc_long <= along;
      acc_lat <= alat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RST;
      inv_mass <= INV_MASS_RST;
      inv_inertia <= INV_INERTIA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_TIME:   step_time <= cfg_data[15:0];
        CFG_INV_MASS:    inv_mass <= cfg_data;
        CFG_INV_INERTIA: inv_inertia <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      yaw <= '0;
      vlong <= '0;
      vlat <= '0;
      yawrate <= '0;
      along <= '0;
      alat <= '0;
      vx_dot <= '0;
      vy_dot <= '0;
      alpha <= '0;
    end else if (ctl.run && ctl.uw.wb_en) begin
      unique case (ctl.uw.dst)
        D_PX:      px <= wb_val;
        D_PY:      py <= wb_val;
        D_YAW:     yaw <= wb_val;
        D_VLONG:   vlong <= wb_val;
        D_VLAT:    vlat <= wb_val;
        D_YAWRATE: yawrate <= wb_val;
        D_ALONG:   along <= wb_val;
        D_ALAT:    alat <= wb_val;
        D_VXDOT:   vx_dot <= wb_val;
        D_VYDOT:   vy_dot <= wb_val;
        D_ALPHA:   alpha <= wb_val;
        default: ;
      endcase
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// testbench for planar_body_euler_step: directed and random force beats checked against a local euler model
module tb_top;

  localparam int FRAC = 16;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_LEN = 300;
  localparam logic [1:0] CFG_NONE = 2'd3;

  // [0] pos_x .. [7] acc_lat
  typedef logic [7:0][31:0] body_vec_t;

  typedef struct packed {
    logic [31:0] f_long;
    logic [31:0] f_lat;
    logic [31:0] torque;
    logic        known;
    body_vec_t   want;
  } force_row_t;

  localparam int TABLE_LEN = 14;
  localparam force_row_t FORCE_TABLE [TABLE_LEN] = '{
    {32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 256'h0},
    {32'h7fffffff, 32'h80000000, 32'h00000000, 1'b1,
     {32'hff7ced91, 32'd8589934, 32'd0, 32'hfffeb0a3, 32'd85852, 32'd0, 32'd0, 32'd0}},
    {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 256'h0},
    {32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 256'h0},
    {32'hffffffff, 32'h00000001, 32'h7fffffff, 1'b0, 256'h0},
    {32'h00000001, 32'hffffffff, 32'h80000000, 1'b0, 256'h0},
    {32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0, 256'h0},
    {32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0, 256'h0},
    {32'h80000000, 32'h7fffffff, 32'h00000000, 1'b0, 256'h0},
    {32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 256'h0},
    {32'h00010000, 32'hffff0000, 32'h00010000, 1'b0, 256'h0},
    {32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 256'h0},
    {32'h80000000, 32'h80000000, 32'h7fffffff, 1'b0, 256'h0},
    {32'h12345678, 32'hedcba987, 32'hfedcba98, 1'b0, 256'h0}
  };

  // zero dt, zero inverses, all maximum, all minimum, moderate
  localparam int FIXED_SETS = 5;
  localparam logic [15:0] SET_DT [FIXED_SETS] = '{16'd0, 16'd655, 16'd65535, 16'd1, 16'd6554};
  localparam logic [31:0] SET_IMASS [FIXED_SETS] =
    '{32'd17179869, 32'd0, 32'hffffffff, 32'd1, 32'd429496730};
  localparam logic [31:0] SET_IINERTIA [FIXED_SETS] =
    '{32'd42949673, 32'd0, 32'hffffffff, 32'd1, 32'd85899346};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] force_long = '0;
  logic [31:0] force_lat = '0;
  logic [31:0] yaw_torque = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pos_x, pos_y, heading, vel_long, vel_lat, turn_rate, acc_long, acc_lat;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic      known_on = 1'b0;
  body_vec_t known_want = '0;

  longint s_px, s_py, s_yaw, s_vlong, s_vlat, s_rate, s_along, s_alat;
  longint dt_now, imass_now, iinertia_now;
  body_vec_t state_due_q [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int unsigned run_cycles = 0;
  string field_tag [8] = '{"pos_x", "pos_y", "heading", "vel_long", "vel_lat",
                           "turn_rate", "acc_long", "acc_lat"};

  planar_body_euler_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .force_long(force_long), .force_lat(force_lat), .yaw_torque(yaw_torque),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .vel_long(vel_long),
    .vel_lat(vel_lat), .turn_rate(turn_rate), .acc_long(acc_long), .acc_lat(acc_lat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_dt(longint v);
    return (v * dt_now) >>> FRAC;
  endfunction

  function automatic longint scale_q032(longint v, longint f);
    return clamp32((v * f) >>> 32);
  endfunction

  function automatic body_vec_t euler_advance(longint fx, longint fy, longint tq);
    longint vx, vy, r, vx_dot, vy_dot, alpha;
    body_vec_t res;
    vx = s_vlong;
    vy = s_vlat;
    r = s_rate;
    s_px = clamp32(s_px + scale_dt(vx));
    s_py = clamp32(s_py + scale_dt(vy));
    s_yaw = clamp32(s_yaw + scale_dt(r));
    s_along = scale_q032(fx, imass_now);
    s_alat = scale_q032(fy, imass_now);
    vx_dot = clamp32(s_along + clamp32((vy * r) >>> FRAC));
    vy_dot = clamp32(s_alat - clamp32((vx * r) >>> FRAC));
    s_vlong = clamp32(vx + scale_dt(vx_dot));
    s_vlat = clamp32(vy + scale_dt(vy_dot));
    alpha = scale_q032(tq, iinertia_now);
    s_rate = clamp32(r + scale_dt(alpha));
    res = {s_alat[31:0], s_along[31:0], s_rate[31:0], s_vlat[31:0],
           s_vlong[31:0], s_yaw[31:0], s_py[31:0], s_px[31:0]};
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    body_vec_t got, want;
    if (rst) begin
      s_px = 0; s_py = 0; s_yaw = 0; s_vlong = 0;
      s_vlat = 0; s_rate = 0; s_along = 0; s_alat = 0;
      dt_now = longint'(pbe_pkg::STEP_TIME_RST);
      imass_now = longint'(pbe_pkg::INV_MASS_RST);
      iinertia_now = longint'(pbe_pkg::INV_INERTIA_RST);
    end else begin
      if (out_valid && out_ready) begin
        got = {acc_lat, acc_long, turn_rate, vel_lat, vel_long, heading, pos_y, pos_x};
        if (state_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", got);
        end else begin
          want = state_due_q.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%s mismatch: expected %h, got %h", field_tag[i], want[i], got[i]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pbe_pkg::CFG_STEP_TIME: dt_now = longint'(cfg_data[15:0]);
          pbe_pkg::CFG_INV_MASS: imass_now = longint'(cfg_data);
          pbe_pkg::CFG_INV_INERTIA: iinertia_now = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = euler_advance(longint'($signed(force_long)), longint'($signed(force_lat)),
                             longint'($signed(yaw_torque)));
        state_due_q = {state_due_q, (known_on ? known_want : want)};
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_taken <= hold_req;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    run_cycles++;
    if (run_cycles > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic offer_forces(input logic [31:0] fl, input logic [31:0] ft,
                              input logic [31:0] tq, input logic known,
                              input body_vec_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    force_long <= fl;
    force_lat <= ft;
    yaw_torque <= tq;
    known_on <= known;
    known_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (state_due_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_force();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h80000000;
          1: v = 32'h7fffffff;
          2: v = 32'h00000000;
          default: v = 32'hffffffff;
        endcase
      end
      1, 2: v = $urandom;
      default: v = $urandom_range(32'h001fffff) - 32'h00100000;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < TABLE_LEN; k++)
      offer_forces(FORCE_TABLE[k].f_long, FORCE_TABLE[k].f_lat, FORCE_TABLE[k].torque,
                   FORCE_TABLE[k].known, FORCE_TABLE[k].want);
    for (int p = 0; p < PHASES; p++) begin
      wait_results();
      repeat (16) @(posedge clk);
      if (p < FIXED_SETS) begin
        write_reg(pbe_pkg::CFG_STEP_TIME, {16'h0, SET_DT[p]});
        write_reg(pbe_pkg::CFG_INV_MASS, SET_IMASS[p]);
        write_reg(pbe_pkg::CFG_INV_INERTIA, SET_IINERTIA[p]);
      end else begin
        write_reg(pbe_pkg::CFG_STEP_TIME, $urandom_range(65535, 1));
        write_reg(pbe_pkg::CFG_INV_MASS, $urandom);
        write_reg(pbe_pkg::CFG_INV_INERTIA, $urandom);
      end
      // out-of-range index must leave the registers alone
      write_reg(CFG_NONE, $urandom);
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 11 : 0;
      stall_pct = (mode == 2) ? 53 : (mode == 3) ? 11 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == 40) hold_req++;
        if (p == 4 && k == 100) wait_results();
        offer_forces(pick_force(), pick_force(), pick_force(), 1'b0, '0);
      end
    end
    wait_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
